// ----- src/lph_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_pkg
// Shared types, codes and helpers of the linear probing hash table.
// ----------------------------------------------------------------------------
package lph_pkg;

    // table geometry defaults
    localparam int SLOTS_DEF = 64;
    localparam int KEY_BYTES = 8;

    // fnv-1a constants
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_MULT  = 32'd16777619;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // one table entry as held in memory
    typedef struct packed {
        logic        used;
        logic [63:0] key;
        logic [15:0] handle;
    } t_slot;

    // keep the name bytes before the first zero byte, within KEY_BYTES bytes
    function automatic logic [63:0] name_of(input logic [63:0] key);
        logic [63:0] res;
        logic        stop;
        logic [7:0]  b;
        res  = '0;
        stop = 1'b0;
        for (int i = 0; i < 8; i++) begin
            b = key[8*i +: 8];
            if (!stop && (i < KEY_BYTES) && (b != 8'd0)) begin
                res[8*i +: 8] = b;
            end else begin
                stop = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// ----- src/lph_cmd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_cmd_if
// Command channel: valid/ready handshake with command, key and handle.
// ----------------------------------------------------------------------------
interface lph_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [63:0] key;
    logic [15:0] handle;

    modport source (output valid, output command, output key, output handle,
                    input ready);
    modport sink   (input valid, input command, input key, input handle,
                    output ready);
endinterface

// ----- src/lph_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_rsp_if
// Response channel: valid/ready handshake with status, handle and count.
// ----------------------------------------------------------------------------
interface lph_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] found_handle;
    logic [6:0]  occupied_count;

    modport source (output valid, output status, output found_handle,
                    output occupied_count, input ready);
    modport sink   (input valid, input status, input found_handle,
                    input occupied_count, output ready);
endinterface

// ----- src/linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open addressing keyed table with fnv-1a home slots and linear probing.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot memory clear, one slot per cycle,
// before it takes its first word. Commands are then handled one at a time.
// Each hash takes in the name bytes one by one, then passes through end of
// name, fold, reciprocal quotient, remainder and hand-over, and each probed
// slot takes a read of the single slot memory, then a check and write. An
// insert or search occupies the block for its hash and its probe, its
// response word becoming valid as the block returns to taking commands. A
// remove adds, for each entry of the cluster behind the removed one, a
// re-hash and new probe, plus a read and check of the slot that ends the
// cluster, so its time grows with the cluster length. A response word still
// waiting for the receiver holds the next one back. One response word is
// returned per command.
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lph_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lph_cmd_if.sink   i_cmd,
    lph_rsp_if.source o_rsp
);
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HASH  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_WRD   = 4'd5;
    localparam logic [3:0] S_WCHK  = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    logic [3:0]       r_state;
    logic [IDX_W-1:0] r_clr;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_k;
    logic [IDX_W-1:0] r_nxt;
    logic [IDX_W-1:0] r_w;
    logic [1:0]       r_cmd;
    logic             r_find;
    logic             r_replace;
    logic [63:0]      r_pkey;
    logic [15:0]      r_phandle;
    logic [CNT_W-1:0] r_count;
    logic [1:0]       r_status;
    logic [15:0]      r_got;
    logic             r_out_valid;
    logic [1:0]       r_out_status;
    logic [15:0]      r_out_handle;
    logic [6:0]       r_out_count;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_slot            ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_slot            ram_q;
    logic             hash_start;
    logic [63:0]      hash_name;
    logic             hash_done;
    logic [IDX_W-1:0] hash_slot;
    logic [63:0]      in_name;
    logic             cmd_known;
    logic             in_fire;
    logic             key_hit;
    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] nxt_inc;

    assign in_name   = name_of(i_cmd.key);
    assign cmd_known = (i_cmd.command == CMD_INSERT) || (i_cmd.command == CMD_SEARCH) ||
                       (i_cmd.command == CMD_REMOVE);
    assign in_fire   = i_cmd.valid && i_cmd.ready;
    assign key_hit   = ram_q.used && (ram_q.key == r_pkey);
    assign idx_inc   = (r_idx == LAST) ? '0 : r_idx + 1'b1;
    assign nxt_inc   = (r_nxt == LAST) ? '0 : r_nxt + 1'b1;

    assign i_cmd.ready = (r_state == S_IDLE);

    // slot memory and hash unit
    lph_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    lph_hash #(
        .SLOTS (SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_name  (hash_name),
        .o_done  (hash_done),
        .o_slot  (hash_slot)
    );

    // memory and hash control
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = '0;
        ram_raddr  = r_idx;
        hash_start = 1'b0;
        hash_name  = in_name;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
            end
            S_IDLE: begin
                hash_start = in_fire && cmd_known;
            end
            S_CHK: begin
                if (!r_find && !ram_q.used) begin
                    ram_we    = 1'b1;
                    ram_wdata = '{used: 1'b1, key: r_pkey, handle: r_phandle};
                end else if (r_find && key_hit && r_cmd == CMD_REMOVE) begin
                    ram_we = 1'b1;
                end
            end
            S_WRD: begin
                ram_raddr = r_nxt;
            end
            S_WCHK: begin
                if (ram_q.used) begin
                    ram_we     = 1'b1;
                    ram_waddr  = r_nxt;
                    hash_start = 1'b1;
                    hash_name  = ram_q.key;
                end
            end
            default: ;
        endcase
    end

    // command sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_cmd     <= i_cmd.command;
                        r_pkey    <= in_name;
                        r_phandle <= i_cmd.handle;
                        r_find    <= (i_cmd.command != CMD_INSERT);
                        r_replace <= 1'b0;
                        r_got     <= '0;
                        r_status  <= ST_NOTFOUND;
                        r_state   <= cmd_known ? S_HASH : S_DONE;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_idx   <= hash_slot;
                        r_k     <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    priority if (!r_find && !ram_q.used) begin
                        r_count <= r_count + 1'b1;
                        if (r_replace) begin
                            r_nxt   <= nxt_inc;
                            r_w     <= r_w + 1'b1;
                            r_state <= S_WRD;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_DONE;
                        end
                    end else if (r_find && !ram_q.used) begin
                        r_state <= S_DONE;
                    end else if (r_find && key_hit) begin
                        r_status <= ST_OK;
                        if (r_cmd == CMD_REMOVE) begin
                            r_count <= r_count - 1'b1;
                            r_nxt   <= idx_inc;
                            r_w     <= '0;
                            r_state <= S_WRD;
                        end else begin
                            r_got   <= ram_q.handle;
                            r_state <= S_DONE;
                        end
                    end else if (r_k == LAST) begin
                        if (!r_find) begin
                            r_status <= ST_FULL;
                        end
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= idx_inc;
                        r_k     <= r_k + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_WRD: begin
                    r_state <= (r_w == LAST) ? S_DONE : S_WCHK;
                end
                S_WCHK: begin
                    if (ram_q.used) begin
                        r_count   <= r_count - 1'b1;
                        r_pkey    <= ram_q.key;
                        r_phandle <= ram_q.handle;
                        r_find    <= 1'b0;
                        r_replace <= 1'b1;
                        r_state   <= S_HASH;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_handle <= r_got;
                        r_out_count  <= 7'(r_count);
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // response word
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.found_handle   = r_out_handle;
    assign o_rsp.occupied_count = r_out_count;

    // occupancy never exceeds the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SLOTS))
        else $error("occupied count beyond table size");

    // no memory write while waiting for a command
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("memory write while idle");

    // a response only comes out of the done state
    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("response raised outside done state");

    // hash results arrive only while the sequencer waits for them
    a_hash_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> r_state == S_HASH)
        else $error("hash finished while not awaited");
endmodule

// ----- src/lph_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/lph_hash.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lph_hash
// Iterative fnv-1a hash of a name, one multiply per byte, then the remainder
// by SLOTS: fold the upper half, reciprocal quotient, subtract.
// ----------------------------------------------------------------------------
module lph_hash
    import lph_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [63:0]              i_name,
    output logic                     o_done,
    output logic [$clog2(SLOTS)-1:0] o_slot
);
    localparam int IDX_W = $clog2(SLOTS);

    // folded value stays below 2^28, so a 29 + IDX_W bit shift is exact
    localparam int          SHIFT   = 29 + IDX_W;
    localparam logic [12:0] FOLD_C  = 13'((1 << 16) % SLOTS);
    localparam logic [63:0] RECIP_W = ((64'd1 << SHIFT) + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
    localparam logic [30:0] RECIP   = RECIP_W[30:0];
    localparam logic [28:0] DIVISOR = 29'(SLOTS);

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MULT = 3'd1;
    localparam logic [2:0] PH_FOLD = 3'd2;
    localparam logic [2:0] PH_QUOT = 3'd3;
    localparam logic [2:0] PH_REM  = 3'd4;

    logic [2:0]       r_phase;
    logic [31:0]      r_h;
    logic [63:0]      r_name;
    logic [3:0]       r_i;
    logic [28:0]      r_fold;
    logic [28:0]      r_quot;
    logic [IDX_W-1:0] r_rem;
    logic             r_done;

    logic [7:0]       cur_byte;
    logic [59:0]      quot_prod;

    // current byte and reciprocal product
    assign cur_byte  = r_name[8*r_i[2:0] +: 8];
    assign quot_prod = {31'd0, r_fold} * {29'd0, RECIP};

    // hash sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_name  <= i_name;
                        r_h     <= FNV_BASIS;
                        r_i     <= 4'd0;
                        r_phase <= PH_MULT;
                    end
                end
                PH_MULT: begin
                    if (r_i[3] || cur_byte == 8'd0) begin
                        r_phase <= PH_FOLD;
                    end else begin
                        r_h <= 32'((r_h ^ {24'd0, cur_byte}) * FNV_MULT);
                        r_i <= r_i + 4'd1;
                    end
                end
                PH_FOLD: begin
                    r_fold  <= 29'(r_h[31:16]) * 29'(FOLD_C) + 29'(r_h[15:0]);
                    r_phase <= PH_QUOT;
                end
                PH_QUOT: begin
                    r_quot  <= 29'(quot_prod >> SHIFT);
                    r_phase <= PH_REM;
                end
                PH_REM: begin
                    r_rem   <= IDX_W'(r_fold - 29'(r_quot * DIVISOR));
                    r_done  <= 1'b1;
                    r_phase <= PH_IDLE;
                end
                default: r_phase <= PH_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_slot = r_rem;
endmodule

// ----- dv/linear_probe_hash_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Self-checking bench for the linear probing hash table. A directed table of
// commands runs first, then random insert/search/remove traffic over a small
// pool of names so that clusters, duplicates, removals and a full table all
// occur. Each response word is compared with a behavioral table model.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_tb;
    import lph_pkg::*;

    localparam int NSLOT     = 64;
    localparam int WDOG_MAX  = 200000;
    localparam int N_RANDOM  = 580;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] handle;
        logic [6:0]  count;
    } t_rsp;

    typedef struct {
        logic [1:0]  command;
        logic [63:0] key;
        logic [15:0] handle;
        bit          typed;
        t_rsp        rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    lph_cmd_if cmd_bus ();
    lph_rsp_if rsp_bus ();

    linear_probe_hash_table #(.SLOTS(NSLOT)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    // model state
    logic [63:0] tbl_key [NSLOT];
    logic [15:0] tbl_hnd [NSLOT];
    bit          tbl_used [NSLOT];
    int          tbl_total;

    t_rsp  rsp_queue [$];
    int    n_err;
    int    idle_cycles;
    bit    hold_long;

    logic [63:0] name_pool [16];

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [63:0] trim_name(input logic [63:0] k);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 8; i++) begin
            if (k[8*i +: 8] == 8'd0) break;
            r[8*i +: 8] = k[8*i +: 8];
        end
        return r;
    endfunction

    function automatic int fnv_slot(input logic [63:0] nm);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < 8; i++) begin
            if (nm[8*i +: 8] == 8'd0) break;
            h = (h ^ {24'd0, nm[8*i +: 8]}) * FNV_MULT;
        end
        return int'(h % NSLOT);
    endfunction

    function automatic bit tbl_place(input logic [63:0] nm, input logic [15:0] hd);
        int idx;
        idx = fnv_slot(nm);
        for (int k = 0; k < NSLOT; k++) begin
            if (!tbl_used[idx]) begin
                tbl_used[idx] = 1;
                tbl_key[idx]  = nm;
                tbl_hnd[idx]  = hd;
                tbl_total++;
                return 1;
            end
            idx = (idx + 1) % NSLOT;
        end
        return 0;
    endfunction

    function automatic int tbl_find(input logic [63:0] nm);
        int idx;
        idx = fnv_slot(nm);
        for (int k = 0; k < NSLOT; k++) begin
            if (!tbl_used[idx]) break;
            if (tbl_key[idx] == nm) return idx;
            idx = (idx + 1) % NSLOT;
        end
        return NSLOT;
    endfunction

    // predicted response of one command, updating the model table
    function automatic t_rsp table_apply(input logic [1:0] c, input logic [63:0] k,
                                         input logic [15:0] hd);
        t_rsp        r;
        logic [63:0] nm;
        int          idx;
        int          nxt;
        logic [63:0] mk;
        logic [15:0] mh;
        nm = trim_name(k);
        r.status = ST_NOTFOUND;
        r.handle = '0;
        if (c == CMD_INSERT) begin
            r.status = tbl_place(nm, hd) ? ST_OK : ST_FULL;
        end else if (c == CMD_SEARCH) begin
            idx = tbl_find(nm);
            if (idx < NSLOT) begin
                r.status = ST_OK;
                r.handle = tbl_hnd[idx];
            end
        end else if (c == CMD_REMOVE) begin
            idx = tbl_find(nm);
            if (idx < NSLOT) begin
                tbl_used[idx] = 0;
                tbl_total--;
                nxt = (idx + 1) % NSLOT;
                for (int j = 0; j + 1 < NSLOT; j++) begin
                    if (!tbl_used[nxt]) break;
                    mk = tbl_key[nxt];
                    mh = tbl_hnd[nxt];
                    tbl_used[nxt] = 0;
                    tbl_total--;
                    void'(tbl_place(mk, mh));
                    nxt = (nxt + 1) % NSLOT;
                end
                r.status = ST_OK;
            end
        end
        r.count = tbl_total[6:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        n_err++;
    endtask

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 5) return 0;
        if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random key, with junk bits past a random terminator when it has one
    function automatic logic [63:0] rand_key();
        logic [63:0] k;
        int          len;
        k = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0) return k;
        len = $urandom_range(0, 8);
        if (len < 8) k[8*len +: 8] = 8'd0;
        return k;
    endfunction

    // send one word, then queue its prediction
    task automatic send_word(input logic [1:0] c, input logic [63:0] k,
                             input logic [15:0] hd, input bit typed, input t_rsp want);
        t_rsp pred;
        int   g;
        g = gap_len();
        if (g > 0) begin
            cmd_bus.valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        cmd_bus.valid   <= 1'b1;
        cmd_bus.command <= c;
        cmd_bus.key     <= k;
        cmd_bus.handle  <= hd;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
        pred = table_apply(c, k, hd);
        if (typed && pred != want) begin
            report_mismatch("table row prediction", pred, want);
        end
        rsp_queue.push_back(pred);
        @(negedge i_clk);
    endtask

    function automatic t_rsp mk_rsp(input logic [1:0] s, input logic [15:0] h,
                                    input int n);
        t_rsp r;
        r.status = s;
        r.handle = h;
        r.count  = n[6:0];
        return r;
    endfunction

    // response checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            if (rsp_queue.size() == 0) begin
                report_mismatch("unexpected word", rsp_bus.status, 0);
            end else begin
                want = rsp_queue.pop_front();
                if (rsp_bus.status != want.status)
                    report_mismatch("status", rsp_bus.status, want.status);
                if (rsp_bus.found_handle != want.handle)
                    report_mismatch("found_handle", rsp_bus.found_handle, want.handle);
                if (rsp_bus.occupied_count != want.count)
                    report_mismatch("occupied_count", rsp_bus.occupied_count,
                                    want.count);
            end
        end
    end

    // receiver readiness with random stalls and one long hold-off
    initial begin
        int g;
        rsp_bus.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                rsp_bus.ready <= 1'b0;
                repeat (600) @(negedge i_clk);
                hold_long = 0;
            end
            g = gap_len();
            if (g == 0) begin
                rsp_bus.ready <= 1'b1;
            end else begin
                rsp_bus.ready <= 1'b0;
                repeat (g - 1) @(negedge i_clk);
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_bus.valid && cmd_bus.ready) ||
            (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_MAX) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_row        rows [$];
        t_row        rw;
        int          pick;
        int          c;
        logic [63:0] k;
        n_err       = 0;
        idle_cycles = 0;
        hold_long   = 0;
        i_rst_n         = 1'b0;
        cmd_bus.valid   = 1'b0;
        cmd_bus.command = CMD_INSERT;
        cmd_bus.key     = '0;
        cmd_bus.handle  = '0;
        for (int i = 0; i < NSLOT; i++) begin
            tbl_used[i] = 0;
            tbl_key[i]  = '0;
            tbl_hnd[i]  = '0;
        end
        tbl_total = 0;
        for (int i = 0; i < 16; i++) name_pool[i] = rand_key();
        name_pool[0] = '0;
        name_pool[1] = 64'h0000_0000_0000_0061;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows: typed rows after reset, extremes and error codes
        rows = '{
            '{CMD_SEARCH, 64'h41, 16'h1234, 1, '{ST_NOTFOUND, 16'h0, 7'd0}},
            '{CMD_REMOVE, 64'h41, 16'h0, 1, '{ST_NOTFOUND, 16'h0, 7'd0}},
            '{2'd3, 64'h41, 16'h0, 1, '{ST_NOTFOUND, 16'h0, 7'd0}},
            '{CMD_INSERT, 64'h0, 16'hFFFF, 1, '{ST_OK, 16'h0, 7'd1}},
            '{CMD_SEARCH, 64'hFF00_0000_0000_0000, 16'h0, 1, '{ST_OK, 16'hFFFF, 7'd1}},
            '{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 1, '{ST_OK, 16'h0, 7'd2}},
            '{CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 16'h5555, 1, '{ST_OK, 16'h0, 7'd2}},
            '{CMD_INSERT, 64'h41, 16'hAAAA, 0, '{2'd0, 16'h0, 7'd0}},
            '{CMD_INSERT, 64'h41, 16'h5555, 0, '{2'd0, 16'h0, 7'd0}},
            '{CMD_SEARCH, 64'h41, 16'h0, 0, '{2'd0, 16'h0, 7'd0}},
            '{CMD_REMOVE, 64'h7700_0041, 16'h0, 0, '{2'd0, 16'h0, 7'd0}},
            '{CMD_SEARCH, 64'h41, 16'h0, 0, '{2'd0, 16'h0, 7'd0}},
            '{CMD_INSERT, 64'h4241, 16'h0101, 0, '{2'd0, 16'h0, 7'd0}},
            '{CMD_REMOVE, 64'h0, 16'h0, 0, '{2'd0, 16'h0, 7'd0}},
            '{CMD_SEARCH, 64'h4241, 16'h0, 0, '{2'd0, 16'h0, 7'd0}},
            '{CMD_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0, 0, '{2'd0, 16'h0, 7'd0}},
            '{2'd3, 64'h4241, 16'hFFFF, 0, '{2'd0, 16'h0, 7'd0}}
        };
        foreach (rows[i]) begin
            rw = rows[i];
            send_word(rw.command, rw.key, rw.handle, rw.typed, rw.rsp);
        end

        // fill to full, prove full, then drain partly
        for (int i = 0; i < NSLOT + 3; i++) begin
            if (i == 8) hold_long = 1;
            send_word(CMD_INSERT, name_pool[$urandom_range(0, 15)], 16'($urandom), 0, '0);
        end
        for (int i = 0; i < 40; i++)
            send_word(CMD_REMOVE, name_pool[$urandom_range(0, 15)], 16'($urandom), 0, '0);

        // random traffic, weighted by fill level
        for (int n = 0; n < N_RANDOM; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                k = name_pool[$urandom_range(0, 15)];
                if ($urandom_range(0, 1)) k[63:56] = 8'($urandom);
                if (trim_name(k) != k && $urandom_range(0, 1)) k = trim_name(k) | 64'h0;
            end else begin
                k = rand_key();
            end
            c = $urandom_range(0, 99);
            if (c < (tbl_total < 40 ? 45 : 25)) c = CMD_INSERT;
            else if (c < 70) c = CMD_SEARCH;
            else if (c < 97) c = CMD_REMOVE;
            else c = 3;
            send_word(c[1:0], k, 16'($urandom), 0, '0);
        end
        cmd_bus.valid <= 1'b0;

        while (rsp_queue.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/lph_pkg.sv
src/lph_cmd_if.sv
src/lph_rsp_if.sv
src/lph_ram.sv
src/lph_hash.sv
src/linear_probe_hash_table.sv
dv/linear_probe_hash_table_tb.sv
